/* hw/rtl/text_console_cell_writer_top_assert.svh */
// Assertion macros used by the file that checks the console.
// The clock is clk and the asynchronous reset is arst_n in every user.
`ifndef TEXT_CONSOLE_CELL_WRITER_TOP_ASSERT_SVH
`define TEXT_CONSOLE_CELL_WRITER_TOP_ASSERT_SVH

// Consequent checked in the same cycle as the antecedent.
`define TCCW_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("text console check failed");

// Consequent checked in the cycle after the antecedent.
`define TCCW_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("text console check failed");

`endif

/* hw/rtl/tccw_pkg.sv */
`timescale 1ns / 1ps

package tccw_pkg;

	// Field widths of the request and result items.
	localparam int FUNC_W = 2;
	localparam int CHAR_W = 8;
	localparam int ROW_W  = 4;
	localparam int COL_W  = 5;

	// Function codes of a request item.
	localparam logic [FUNC_W-1:0] FUNC_PUT   = 2'd0;
	localparam logic [FUNC_W-1:0] FUNC_READ  = 2'd1;
	localparam logic [FUNC_W-1:0] FUNC_CLEAR = 2'd2;

	// Control characters handled by a put.
	localparam logic [CHAR_W-1:0] CH_NEWLINE   = 8'd10;
	localparam logic [CHAR_W-1:0] CH_BACKSPACE = 8'd8;

	typedef struct packed {
		logic [FUNC_W-1:0] func;
		logic [CHAR_W-1:0] char_code;
		logic [ROW_W-1:0]  read_row;
		logic [COL_W-1:0]  read_col;
	} in_item_t;

	typedef struct packed {
		logic [CHAR_W-1:0] cell_value;
		logic [ROW_W-1:0]  cursor_row;
		logic [COL_W-1:0]  cursor_col;
		logic              scrolled;
	} out_item_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic load;
		logic exec;
		logic scroll_begin;
		logic clear_begin;
		logic sweep;
		logic write_char;
		logic respond;
	} dp_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic is_clear;
		logic is_read;
		logic need_scroll;
		logic put_char;
		logic sweep_last;
	} dp_status_t;

endpackage

/* hw/rtl/text_console_cell_writer_top.sv */
`timescale 1ns / 1ps

// Character-cell text console with scroll. A request item is taken when start is
// high and busy is low; exactly one result item follows, shown on result for the
// single cycle in which done is high, and it cannot be held off, so capture it
// then. The next item may be started in that same cycle. A plain put, a backspace
// or an unused code is finished in the execute state; a read also passes a wait
// state, as its cell comes from the registered read port of the screen memory. A
// newline that scrolls, and a stored byte that scrolls, first blank the freed
// bottom row one cell a cycle through the single write port, and a stored byte is
// then written in a write state; a clear blanks the whole memory the same way.
// Scrolling moves no data: a circular top-row pointer renames the rows. After
// reset the block runs a clearing pass over the whole memory with busy high.
module text_console_cell_writer_top #(
	parameter int ROWS = 10,
	parameter int COLS = 24
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	output logic                 busy,
	input  tccw_pkg::in_item_t   request,
	output logic                 done,
	output tccw_pkg::out_item_t  result
);

	tccw_pkg::dp_cmd_t    cmd;
	tccw_pkg::dp_status_t status;

	// Sequencing of each item.
	tccw_ctrl u_ctrl (
		.clk   (clk),
		.arst_n(arst_n),
		.start (start),
		.status(status),
		.cmd   (cmd),
		.busy  (busy)
	);

	// Cursor, screen memory and result register.
	tccw_datapath #(
		.ROWS(ROWS),
		.COLS(COLS)
	) u_dp (
		.clk    (clk),
		.arst_n (arst_n),
		.request(request),
		.cmd    (cmd),
		.status (status),
		.result (result),
		.done   (done)
	);

endmodule

/* hw/rtl/tccw_ram.sv */
`timescale 1ns / 1ps

module tccw_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 240
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// One write port and one registered read port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

/* hw/rtl/tccw_ctrl.sv */
`timescale 1ns / 1ps

module tccw_ctrl (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   start,
	input  tccw_pkg::dp_status_t   status,
	output tccw_pkg::dp_cmd_t      cmd,
	output logic                   busy
);

	typedef enum logic [6:0] {
		ST_INIT      = 7'b0000001,
		ST_IDLE      = 7'b0000010,
		ST_EXEC      = 7'b0000100,
		ST_RDWAIT    = 7'b0001000,
		ST_SWEEP_ROW = 7'b0010000,
		ST_SWEEP_CLR = 7'b0100000,
		ST_WRITE     = 7'b1000000
	} state_t;

	state_t state_q, state_d;

	// Next state and command decode.
	always_comb begin
		state_d = state_q;
		cmd     = '0;
		case (state_q)
			ST_INIT: begin
				cmd.sweep = 1'b1;
				if (status.sweep_last) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				if (start) begin
					cmd.load = 1'b1;
					state_d  = ST_EXEC;
				end
			end
			ST_EXEC: begin
				if (status.is_clear) begin
					cmd.clear_begin = 1'b1;
					state_d         = ST_SWEEP_CLR;
				end else if (status.need_scroll) begin
					cmd.scroll_begin = 1'b1;
					state_d          = ST_SWEEP_ROW;
				end else if (status.is_read) begin
					state_d = ST_RDWAIT;
				end else begin
					cmd.exec    = 1'b1;
					cmd.respond = 1'b1;
					state_d     = ST_IDLE;
				end
			end
			ST_RDWAIT: begin
				cmd.respond = 1'b1;
				state_d     = ST_IDLE;
			end
			ST_SWEEP_ROW: begin
				cmd.sweep = 1'b1;
				if (status.sweep_last) begin
					if (status.put_char) begin
						state_d = ST_WRITE;
					end else begin
						cmd.respond = 1'b1;
						state_d     = ST_IDLE;
					end
				end
			end
			ST_SWEEP_CLR: begin
				cmd.sweep = 1'b1;
				if (status.sweep_last) begin
					cmd.respond = 1'b1;
					state_d     = ST_IDLE;
				end
			end
			ST_WRITE: begin
				cmd.write_char = 1'b1;
				cmd.respond    = 1'b1;
				state_d        = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// State register; reset starts the clearing pass.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_INIT;
		end else begin
			state_q <= state_d;
		end
	end

	assign busy = (state_q != ST_IDLE);

endmodule

/* hw/rtl/tccw_datapath.sv */
`timescale 1ns / 1ps

module tccw_datapath #(
	parameter int ROWS = 10,
	parameter int COLS = 24
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  tccw_pkg::in_item_t    request,
	input  tccw_pkg::dp_cmd_t     cmd,
	output tccw_pkg::dp_status_t  status,
	output tccw_pkg::out_item_t   result,
	output logic                  done
);

	localparam int DEPTH = ROWS * COLS;
	localparam int AW    = $clog2(DEPTH);
	localparam int RW    = $clog2(ROWS);
	localparam int CW    = $clog2(COLS + 1);
	localparam int ORW   = tccw_pkg::ROW_W;
	localparam int OCW   = tccw_pkg::COL_W;
	localparam int DW    = tccw_pkg::CHAR_W;

	localparam logic [RW:0]   ROWS_E   = (RW + 1)'(ROWS);
	localparam logic [RW-1:0] LAST_ROW = RW'(ROWS - 1);
	localparam logic [CW-1:0] COLS_C   = CW'(COLS);
	localparam logic [AW-1:0] COLS_A   = AW'(COLS);
	localparam logic [AW-1:0] LAST_A   = AW'(DEPTH - 1);

	tccw_pkg::in_item_t  item_q;
	tccw_pkg::out_item_t result_q;
	logic                done_q;

	logic [RW-1:0] row_q, row_d;
	logic [CW-1:0] col_q, col_d;
	logic [RW-1:0] top_q, top_d;
	logic          scrolled_q;
	logic [AW-1:0] sweep_addr_q, sweep_end_q;

	logic          we;
	logic [AW-1:0] waddr;
	logic [DW-1:0] wdata;
	logic [AW-1:0] raddr;
	logic [DW-1:0] rdata;

	logic is_put, is_read, is_clear, ch_nl, ch_bs, wrap, at_bottom, need_line;
	logic rd_in_range;
	logic [AW-1:0] scroll_base;

	// Logical row to storage row through the circular top pointer.
	function automatic logic [RW-1:0] phys_row(input logic [RW-1:0] lr,
	                                           input logic [RW-1:0] top);
		logic [RW:0] s;
		s = {1'b0, lr} + {1'b0, top};
		if (s >= ROWS_E) begin
			s = s - ROWS_E;
		end
		return s[RW-1:0];
	endfunction

	function automatic logic [AW-1:0] cell_addr(input logic [RW-1:0] prow,
	                                            input logic [CW-1:0] col);
		return AW'(prow) * COLS_A + AW'(col);
	endfunction

	// Decode of the held item.
	assign is_put      = (item_q.func == tccw_pkg::FUNC_PUT);
	assign is_read     = (item_q.func == tccw_pkg::FUNC_READ);
	assign is_clear    = (item_q.func == tccw_pkg::FUNC_CLEAR);
	assign ch_nl       = (item_q.char_code == tccw_pkg::CH_NEWLINE);
	assign ch_bs       = (item_q.char_code == tccw_pkg::CH_BACKSPACE);
	assign wrap        = (col_q >= COLS_C);
	assign at_bottom   = (row_q == LAST_ROW);
	assign need_line   = is_put && (ch_nl || (!ch_bs && wrap));
	assign rd_in_range = (int'(item_q.read_row) < ROWS) && (int'(item_q.read_col) < COLS);

	// The row that scrolls off the top becomes the new bottom row.
	assign scroll_base = AW'(top_q) * COLS_A;

	assign status.is_clear    = is_clear;
	assign status.is_read     = is_read;
	assign status.need_scroll = need_line && at_bottom;
	assign status.put_char    = is_put && !ch_nl;
	assign status.sweep_last  = (sweep_addr_q == sweep_end_q);

	assign raddr = cell_addr(phys_row(RW'(item_q.read_row), top_q), CW'(item_q.read_col));

	// Cursor update and the single write port of the screen store.
	always_comb begin
		row_d = row_q;
		col_d = col_q;
		top_d = top_q;
		we    = 1'b0;
		waddr = sweep_addr_q;
		wdata = '0;
		if (cmd.sweep) begin
			we = 1'b1;
		end
		if (cmd.clear_begin) begin
			row_d = '0;
			col_d = '0;
			top_d = '0;
		end
		if (cmd.scroll_begin) begin
			top_d = (top_q == LAST_ROW) ? '0 : top_q + 1'b1;
			row_d = LAST_ROW;
			col_d = '0;
		end
		if (cmd.write_char) begin
			we    = 1'b1;
			waddr = cell_addr(phys_row(row_q, top_q), col_q);
			wdata = item_q.char_code;
			col_d = col_q + 1'b1;
		end
		if (cmd.exec && is_put) begin
			if (ch_nl) begin
				row_d = row_q + 1'b1;
				col_d = '0;
			end else if (ch_bs) begin
				if (col_q != '0) begin
					col_d = col_q - 1'b1;
					we    = 1'b1;
					waddr = cell_addr(phys_row(row_q, top_q), col_q - 1'b1);
				end
			end else if (wrap) begin
				row_d = row_q + 1'b1;
				col_d = CW'(1);
				we    = 1'b1;
				waddr = cell_addr(phys_row(row_q + 1'b1, top_q), '0);
				wdata = item_q.char_code;
			end else begin
				col_d = col_q + 1'b1;
				we    = 1'b1;
				waddr = cell_addr(phys_row(row_q, top_q), col_q);
				wdata = item_q.char_code;
			end
		end
	end

	// Control registers: cursor, top pointer, scroll flag, sweep range and result strobe.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_q        <= '0;
			col_q        <= '0;
			top_q        <= '0;
			scrolled_q   <= 1'b0;
			sweep_addr_q <= '0;
			sweep_end_q  <= LAST_A;
			done_q       <= 1'b0;
		end else begin
			row_q  <= row_d;
			col_q  <= col_d;
			top_q  <= top_d;
			done_q <= cmd.respond;
			if (cmd.load) begin
				scrolled_q <= 1'b0;
			end else if (cmd.scroll_begin) begin
				scrolled_q <= 1'b1;
			end
			if (cmd.clear_begin) begin
				sweep_addr_q <= '0;
				sweep_end_q  <= LAST_A;
			end else if (cmd.scroll_begin) begin
				sweep_addr_q <= scroll_base;
				sweep_end_q  <= scroll_base + COLS_A - 1'b1;
			end else if (cmd.sweep) begin
				sweep_addr_q <= sweep_addr_q + 1'b1;
			end
		end
	end

	// Payload registers: the held item and the result item.
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			item_q <= request;
		end
		if (cmd.respond) begin
			result_q.cell_value <= (is_read && rd_in_range) ? rdata : '0;
			result_q.cursor_row <= ORW'(row_d);
			result_q.cursor_col <= OCW'(col_d);
			result_q.scrolled   <= scrolled_q;
		end
	end

	tccw_ram #(
		.WIDTH(DW),
		.DEPTH(DEPTH)
	) u_screen (
		.clk  (clk),
		.we   (we),
		.waddr(waddr),
		.wdata(wdata),
		.raddr(raddr),
		.rdata(rdata)
	);

	assign result = result_q;
	assign done   = done_q;

endmodule

/* hw/rtl/tccw_checker.sv */
`timescale 1ns / 1ps

`include "text_console_cell_writer_top_assert.svh"

module tccw_checker (
	input logic                 clk,
	input logic                 arst_n,
	input logic                 start,
	input logic                 busy,
	input logic                 done,
	input tccw_pkg::out_item_t  result
);

	// An accepted item keeps the block busy in the next cycle.
	`TCCW_ASSERT_NEXT(a_busy_after_accept, start && !busy, busy)

	// A result item only follows a cycle of work.
	`TCCW_ASSERT_NOW(a_done_after_busy, done, $past(busy))

	// The idle state never responds, so result strobes never touch.
	`TCCW_ASSERT_NEXT(a_done_single, done, !done)

	// A scroll leaves the cursor at column 0, or 1 after a stored byte.
	`TCCW_ASSERT_NOW(a_scroll_col, done && result.scrolled,
		result.cursor_col == 5'd0 || result.cursor_col == 5'd1)

endmodule

bind text_console_cell_writer_top tccw_checker u_tccw_checker (
	.clk   (clk),
	.arst_n(arst_n),
	.start (start),
	.busy  (busy),
	.done  (done),
	.result(result)
);
